### src/gd3e_pkg.sv
package gd3e_pkg;

  // Port and field widths
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 16;
  localparam int SIZE_W  = 6;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 16;
  localparam int RES_W   = 17;
  localparam int SP_W    = 16;
  // Squared Q8.8 value, and the same saturated one bit above it
  localparam int SQ_W    = 32;
  localparam int CAP_W   = SQ_W + 1;
  // Signed neighbor coordinate: position plus or minus the reach
  localparam int COORD_W = 7;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SIZE_X    = 3'd0,
    REG_SIZE_Y    = 3'd1,
    REG_SIZE_Z    = 3'd2,
    REG_SPACING_X = 3'd3,
    REG_SPACING_Y = 3'd4,
    REG_SPACING_Z = 3'd5,
    REG_RADIUS    = 3'd6,
    REG_OFFSET    = 3'd7
  } reg_idx_e;

  // Request kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_ASK   = 1'b1;

  // Live configuration, sizes already clipped to the volume side
  typedef struct packed {
    logic        [SIZE_W-1:0] size_x;
    logic        [SIZE_W-1:0] size_y;
    logic        [SIZE_W-1:0] size_z;
    logic        [SP_W-1:0]   spacing_x;
    logic        [SP_W-1:0]   spacing_y;
    logic        [SP_W-1:0]   spacing_z;
    logic        [SP_W-1:0]   radius;
    logic signed [VAL_W-1:0]  offset;
  } cfg_t;

endpackage

### src/gd3e_cfg.sv
module gd3e_cfg #(
  parameter int SIDE = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gd3e_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [gd3e_pkg::CFG_W-1:0]  cfg_data_i,
  output gd3e_pkg::cfg_t              cfg_o
);
  import gd3e_pkg::*;

  localparam logic [8:0] SIDE_L = 9'(SIDE);

  logic        [SIZE_W-1:0] size_x_q, size_y_q, size_z_q;
  logic        [SP_W-1:0]   spacing_x_q, spacing_y_q, spacing_z_q;
  logic        [SP_W-1:0]   radius_q;
  logic signed [VAL_W-1:0]  offset_q;

  // Register file writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q    <= 6'd32;
      size_y_q    <= 6'd32;
      size_z_q    <= 6'd32;
      spacing_x_q <= 16'd256;
      spacing_y_q <= 16'd256;
      spacing_z_q <= 16'd256;
      radius_q    <= 16'd256;
      offset_q    <= '0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SIZE_X:    size_x_q    <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Y:    size_y_q    <= cfg_data_i[SIZE_W-1:0];
        REG_SIZE_Z:    size_z_q    <= cfg_data_i[SIZE_W-1:0];
        REG_SPACING_X: spacing_x_q <= cfg_data_i;
        REG_SPACING_Y: spacing_y_q <= cfg_data_i;
        REG_SPACING_Z: spacing_z_q <= cfg_data_i;
        REG_RADIUS:    radius_q    <= cfg_data_i;
        REG_OFFSET:    offset_q    <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Sizes beyond the volume side are treated as the side
  function automatic logic [SIZE_W-1:0] clip_size(input logic [SIZE_W-1:0] s);
    logic [8:0] s9;
    s9 = 9'(s);
    return (s9 > SIDE_L) ? SIDE_L[SIZE_W-1:0] : s;
  endfunction

  always_comb begin
    cfg_o.size_x    = clip_size(size_x_q);
    cfg_o.size_y    = clip_size(size_y_q);
    cfg_o.size_z    = clip_size(size_z_q);
    cfg_o.spacing_x = spacing_x_q;
    cfg_o.spacing_y = spacing_y_q;
    cfg_o.spacing_z = spacing_z_q;
    cfg_o.radius    = radius_q;
    cfg_o.offset    = offset_q;
  end

endmodule

### src/gray_dilate_3d_ellipsoid.sv
// Channel   Direction  Ports                                          Handshake
// request   in         kind_i pos_x_i pos_y_i pos_z_i voxel_value_i   start & !busy
// result    out        dilated_value_o                                done_o, one cycle
// config    in         cfg_idx_i cfg_data_i                           cfg_we_i
//
// A store leaves busy low. An ask outside the sizes answers
// on the next cycle. An ask inside holds busy through the setup states (ST_R2, then
// ST_SQ and ST_TAB per axis, then ST_OWN), then scans the (2rx+1)(2ry+1)(2rz+1)
// neighbors one per cycle through the single volume read port, then drains the
// read pipeline, with done_o high in the cycle busy falls.
// No clearing pass after reset; done_o cannot be held off by the receiver.
module gray_dilate_3d_ellipsoid #(
  parameter int SIDE      = 32,
  parameter int MAX_REACH = 7
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               kind_i,
  input  logic        [gd3e_pkg::POS_W-1:0]  pos_x_i,
  input  logic        [gd3e_pkg::POS_W-1:0]  pos_y_i,
  input  logic        [gd3e_pkg::POS_W-1:0]  pos_z_i,
  input  logic signed [gd3e_pkg::VAL_W-1:0]  voxel_value_i,
  input  logic                               cfg_we_i,
  input  logic        [gd3e_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic        [gd3e_pkg::CFG_W-1:0]  cfg_data_i,
  output logic                               done_o,
  output logic signed [gd3e_pkg::RES_W-1:0]  dilated_value_o
);
  import gd3e_pkg::*;

  localparam int RW     = $clog2(MAX_REACH + 1);
  localparam int TAB_N  = MAX_REACH + 1;
  localparam int DEPTH  = SIDE * SIDE * SIDE;
  localparam int AW     = $clog2(DEPTH);
  localparam int DW     = SQ_W + 2 * RW + 1;
  localparam int NUM_W  = SP_W + 2;
  localparam int STEP_W = SP_W + 1;
  localparam int ACC_W  = STEP_W + RW + 1;
  localparam int SUM_W  = CAP_W + 2;
  localparam logic [RW-1:0] MAX_R = RW'(MAX_REACH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_R2, ST_SQ, ST_TAB, ST_OWN, ST_SCAN, ST_DRAIN
  } state_e;

  typedef enum logic [1:0] {AX_X, AX_Y, AX_Z} axis_e;

  cfg_t cfg;

  gd3e_cfg #(.SIDE(SIDE)) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Control state
  state_e                state_q;
  axis_e                 axis_q;
  logic [RW-1:0]         q_q;
  logic [RW-1:0]         rx_q, ry_q, rz_q;
  logic signed [RW:0]    i_q, j_q, k_q;
  logic                  v1_q, own1_q, v2_q, own2_q;

  // Datapath state
  logic [POS_W-1:0]      pos_x_q, pos_y_q, pos_z_q;
  logic [SQ_W-1:0]       r2_q, sq_q;
  logic [DW-1:0]         d_q, e_q;
  logic [NUM_W-1:0]      num_q;
  logic [STEP_W-1:0]     step_q;
  logic [ACC_W-1:0]      acc_q;
  logic [CAP_W-1:0]      tabx_q [TAB_N];
  logic [CAP_W-1:0]      taby_q [TAB_N];
  logic [CAP_W-1:0]      tabz_q [TAB_N];
  logic [AW-1:0]         addr1_q;
  logic signed [VAL_W-1:0] rdata_q;
  logic signed [RES_W-1:0] best_q;
  logic [VAL_W-1:0]      vol_mem [DEPTH];

  function automatic logic [AW-1:0] vox_addr(input logic [SIZE_W-1:0] a,
                                             input logic [SIZE_W-1:0] b,
                                             input logic [SIZE_W-1:0] c);
    logic [AW-1:0] row;
    row = AW'(AW'(c) * AW'(SIDE) + AW'(b));
    return AW'(row * AW'(SIDE) + AW'(a));
  endfunction

  function automatic logic [CAP_W-1:0] cap_sq(input logic [DW-1:0] d);
    return (|d[DW-1:SQ_W]) ? {1'b1, {SQ_W{1'b0}}} : {1'b0, d[SQ_W-1:0]};
  endfunction

  // Request decode
  logic accept, inside_in;
  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign inside_in = (SIZE_W'(pos_x_i) < cfg.size_x) && (SIZE_W'(pos_y_i) < cfg.size_y) &&
                     (SIZE_W'(pos_z_i) < cfg.size_z);

  // Shared squaring multiplier: radius once, then each spacing
  logic [SP_W-1:0] sp_sel, mul_a;
  logic [SQ_W-1:0] mul_p;
  always_comb begin
    case (axis_q)
      AX_X:    sp_sel = cfg.spacing_x;
      AX_Y:    sp_sel = cfg.spacing_y;
      AX_Z:    sp_sel = cfg.spacing_z;
      default: sp_sel = cfg.spacing_z;
    endcase
    mul_a = (state_q == ST_R2) ? cfg.radius : sp_sel;
    mul_p = SQ_W'(mul_a * mul_a);
  end

  // Reach step: keep counting while 2s(q+1) <= 2R + s, up to the clip
  logic more;
  assign more = (q_q != MAX_R) && (acc_q <= ACC_W'(num_q));

  // Scan address generation and neighborhood test
  logic [RW-1:0]              absi, absj, absk;
  logic signed [COORD_W-1:0]  ca, cb, cc;
  logic                       in_a, in_b, in_c;
  logic [SUM_W-1:0]           dsum;
  logic                       scan_ok;
  logic [AW-1:0]              scan_addr;
  logic                       last_i, last_j, last_k;
  logic signed [RW:0]         nrx, nry, nrz;

  always_comb begin
    absi = i_q[RW] ? RW'(-i_q) : RW'(i_q);
    absj = j_q[RW] ? RW'(-j_q) : RW'(j_q);
    absk = k_q[RW] ? RW'(-k_q) : RW'(k_q);
    ca   = signed'(COORD_W'(pos_x_q)) + COORD_W'(i_q);
    cb   = signed'(COORD_W'(pos_y_q)) + COORD_W'(j_q);
    cc   = signed'(COORD_W'(pos_z_q)) + COORD_W'(k_q);
    in_a = !ca[COORD_W-1] && (ca[SIZE_W-1:0] < cfg.size_x);
    in_b = !cb[COORD_W-1] && (cb[SIZE_W-1:0] < cfg.size_y);
    in_c = !cc[COORD_W-1] && (cc[SIZE_W-1:0] < cfg.size_z);
    dsum = SUM_W'(tabx_q[absi]) + SUM_W'(taby_q[absj]) + SUM_W'(tabz_q[absk]);
    scan_ok   = in_a && in_b && in_c && (dsum <= SUM_W'(r2_q));
    scan_addr = vox_addr(ca[SIZE_W-1:0], cb[SIZE_W-1:0], cc[SIZE_W-1:0]);
    nrx = -signed'({1'b0, rx_q});
    nry = -signed'({1'b0, ry_q});
    nrz = -signed'({1'b0, rz_q});
    last_i = (i_q == signed'({1'b0, rx_q}));
    last_j = (j_q == signed'({1'b0, ry_q}));
    last_k = (k_q == signed'({1'b0, rz_q}));
  end

  // Candidate: neighbor plus offset
  logic signed [RES_W-1:0] cand;
  assign cand = RES_W'(rdata_q) + RES_W'(cfg.offset);

  // Sequencer, pipeline valids and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      axis_q          <= AX_X;
      q_q             <= '0;
      rx_q            <= '0;
      ry_q            <= '0;
      rz_q            <= '0;
      i_q             <= '0;
      j_q             <= '0;
      k_q             <= '0;
      v1_q            <= 1'b0;
      own1_q          <= 1'b0;
      v2_q            <= 1'b0;
      own2_q          <= 1'b0;
      done_o          <= 1'b0;
      dilated_value_o <= '0;
    end else begin
      done_o <= 1'b0;
      v2_q   <= v1_q;
      own2_q <= own1_q;
      v1_q   <= 1'b0;
      own1_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept && kind_i == KIND_ASK) begin
            if (inside_in) begin
              state_q <= ST_R2;
            end else begin
              done_o          <= 1'b1;
              dilated_value_o <= '0;
            end
          end
        end
        ST_R2: begin
          axis_q  <= AX_X;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          q_q     <= '0;
          state_q <= ST_TAB;
        end
        ST_TAB: begin
          if (more) begin
            q_q <= q_q + 1'b1;
          end else begin
            case (axis_q)
              AX_X: begin
                rx_q    <= q_q;
                axis_q  <= AX_Y;
                state_q <= ST_SQ;
              end
              AX_Y: begin
                ry_q    <= q_q;
                axis_q  <= AX_Z;
                state_q <= ST_SQ;
              end
              default: begin
                rz_q    <= q_q;
                state_q <= ST_OWN;
              end
            endcase
          end
        end
        ST_OWN: begin
          v1_q    <= 1'b1;
          own1_q  <= 1'b1;
          i_q     <= nrx;
          j_q     <= nry;
          k_q     <= nrz;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          v1_q <= scan_ok;
          if (!last_i) begin
            i_q <= i_q + 1'b1;
          end else begin
            i_q <= nrx;
            if (!last_j) begin
              j_q <= j_q + 1'b1;
            end else begin
              j_q <= nry;
              if (!last_k) begin
                k_q <= k_q + 1'b1;
              end else begin
                state_q <= ST_DRAIN;
              end
            end
          end
        end
        ST_DRAIN: begin
          if (!v1_q && !v2_q) begin
            done_o          <= 1'b1;
            dilated_value_o <= best_q;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers: reach setup, distance tables, address and maximum
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_x_q <= pos_x_i;
          pos_y_q <= pos_y_i;
          pos_z_q <= pos_z_i;
        end
      end
      ST_R2: r2_q <= mul_p;
      ST_SQ: begin
        sq_q   <= mul_p;
        e_q    <= DW'(mul_p);
        d_q    <= '0;
        num_q  <= NUM_W'({cfg.radius, 1'b0}) + NUM_W'(sp_sel);
        step_q <= {sp_sel, 1'b0};
        acc_q  <= ACC_W'({sp_sel, 1'b0});
      end
      ST_TAB: begin
        // (q*s)^2 built from running sums of (2q+1)*s^2
        case (axis_q)
          AX_X:    tabx_q[q_q] <= cap_sq(d_q);
          AX_Y:    taby_q[q_q] <= cap_sq(d_q);
          default: tabz_q[q_q] <= cap_sq(d_q);
        endcase
        if (more) begin
          acc_q <= acc_q + ACC_W'(step_q);
          d_q   <= d_q + e_q;
          e_q   <= e_q + DW'({sq_q, 1'b0});
        end
      end
      ST_OWN:  addr1_q <= vox_addr(SIZE_W'(pos_x_q), SIZE_W'(pos_y_q), SIZE_W'(pos_z_q));
      ST_SCAN: addr1_q <= scan_addr;
      default: ;
    endcase
    // Running maximum; the center value enters without offset
    if (v2_q) begin
      if (own2_q) begin
        best_q <= RES_W'(rdata_q);
      end else if (cand > best_q) begin
        best_q <= cand;
      end
    end
  end

  // Volume memory: store port and registered read port
  always_ff @(posedge clk_i) begin
    if (accept && kind_i == KIND_STORE && inside_in) begin
      vol_mem[vox_addr(SIZE_W'(pos_x_i), SIZE_W'(pos_y_i), SIZE_W'(pos_z_i))] <= voxel_value_i;
    end
    rdata_q <= signed'(vol_mem[addr1_q]);
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!v1_q && !v2_q))
    else $error("read pipeline not empty while idle");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_fell_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("ask finished without a result");

  a_scan_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (absi <= rx_q && absj <= ry_q && absk <= rz_q))
    else $error("scan offset beyond axis reach");
`endif

endmodule
